// ===== rtl/akfg_pkg.sv =====
// ----------------------------------------------------------------------------
// akfg_pkg: shared types and constants for the Annex-B keyframe gate
// Command and verdict codes, codec modes and NAL header constants.
// ----------------------------------------------------------------------------
package akfg_pkg;

  typedef enum logic [1:0] {
    CMD_UNIT_BYTE = 2'd0,
    CMD_MS_TICK   = 2'd1,
    CMD_DEC_ERROR = 2'd2,
    CMD_BACKLOG   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_DROP_LOSS = 2'd1,
    VERDICT_DROP_WAIT = 2'd2,
    VERDICT_EVENT     = 2'd3
  } verdict_t;

  // Codec modes; any code above HEVC uses the transport hint
  localparam logic [1:0] MODE_H264 = 2'd0;
  localparam logic [1:0] MODE_HEVC = 2'd1;

  // Config register indexes
  localparam logic CFG_CODEC_MODE   = 1'b0;
  localparam logic CFG_REQ_INTERVAL = 1'b1;

  localparam int          CFG_DATA_W           = 16;
  localparam int          MS_W                 = 16;
  localparam logic [MS_W-1:0] MS_SATURATED     = '1;
  localparam logic [1:0]  CODEC_MODE_RESET     = MODE_H264;
  localparam logic [15:0] REQ_INTERVAL_RESET   = 16'd700;

  // NAL header constants
  localparam logic [4:0] H264_IDR_TYPE  = 5'd5;
  localparam logic [5:0] HEVC_IRAP_LOW  = 6'd16;
  localparam logic [5:0] HEVC_IRAP_HIGH = 6'd23;

  // Start code: at least two zero bytes then 0x01
  localparam logic [1:0] ZERO_RUN_MAX   = 2'd2;
  localparam logic [7:0] START_CODE_END = 8'h01;

endpackage

// ===== rtl/annexb_keyframe_gate_unit.sv =====
// The result of an accepted input transaction is loaded straight into the output register.
// Throughput: one input transaction per cycle; byte scan and gate decision share one pass.
// The input side stalls only while a finished result waits on a stalled output.
// Reset (rst, synchronous, active high): clears the scan, sets keyframe waiting,
// saturates the request timer at 65535, restores codec_mode 0 and interval 700 ms.
// ----------------------------------------------------------------------------
// annexb_keyframe_gate_unit: Annex-B keyframe gate
// Scans access-unit bytes for start codes and NAL headers, passes or drops
// each unit on its last byte and issues throttled keyframe requests.
// ----------------------------------------------------------------------------
module annexb_keyframe_gate_unit import akfg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  loss_suspected,
  input  logic                  keyframe_hint,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            verdict,
  output logic                  keyframe_request,
  output logic                  keyframe_found,
  output logic                  waiting_after
);

  // Configuration registers
  logic [1:0]      codec_mode;
  logic [15:0]     request_interval_ms;

  // Scan and gate state
  logic [1:0]      zero_run, zero_run_next;
  logic            header_next, header_next_next;
  logic            hevc_irap_pending, hevc_irap_pending_next;
  logic            key_seen, key_seen_next;
  logic            awaiting_key, awaiting_key_next;
  logic [MS_W-1:0] ms_since_request, ms_since_request_next;

  // Result register
  logic            res_valid_next;
  verdict_t        res_verdict, res_verdict_next;
  logic            res_request, res_request_next;
  logic            res_found, res_found_next;
  logic            res_waiting, res_waiting_next;

  logic            accept;
  cmd_t            cmd;

  // Scan of the incoming byte
  logic            scan_key;
  logic            scan_irap;
  logic            scan_header;
  logic [1:0]      scan_zero_run;
  logic [5:0]      hevc_type;
  logic            unit_key;
  logic            req_ok;

  // Hold the input side only while a result waits on a stalled output
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(command);

  assign hevc_type = data_byte[6:1];

  always_comb begin
    // A pending HEVC IRAP header counts once any further byte arrives
    scan_key  = key_seen || hevc_irap_pending ||
                (header_next && (codec_mode != MODE_HEVC) &&
                 (data_byte[4:0] == H264_IDR_TYPE));
    scan_irap = header_next && (codec_mode == MODE_HEVC) &&
                (hevc_type >= HEVC_IRAP_LOW) && (hevc_type <= HEVC_IRAP_HIGH);
    scan_header = (data_byte == START_CODE_END) && (zero_run >= ZERO_RUN_MAX);
    if (data_byte == 8'd0) begin
      scan_zero_run = (zero_run < ZERO_RUN_MAX) ? zero_run + 2'd1 : zero_run;
    end else begin
      scan_zero_run = 2'd0;
    end
  end

  // Scan modes judge by what the scan saw; the other modes trust the transport
  assign unit_key = (codec_mode == MODE_H264 || codec_mode == MODE_HEVC) ?
                    scan_key : keyframe_hint;
  assign req_ok   = ms_since_request >= request_interval_ms;

  always_comb begin
    zero_run_next          = zero_run;
    header_next_next       = header_next;
    hevc_irap_pending_next = hevc_irap_pending;
    key_seen_next          = key_seen;
    awaiting_key_next      = awaiting_key;
    ms_since_request_next  = ms_since_request;
    res_valid_next         = 1'b0;
    res_verdict_next       = VERDICT_EVENT;
    res_request_next       = 1'b0;
    res_found_next         = 1'b0;

    if (accept) begin
      unique case (cmd)
        CMD_MS_TICK: begin
          // Advance the request timer, saturate at the top
          if (ms_since_request != MS_SATURATED) begin
            ms_since_request_next = ms_since_request + 1'b1;
          end
        end
        CMD_DEC_ERROR, CMD_BACKLOG: begin
          // Start waiting and try a request; leave the unit scan alone
          awaiting_key_next = 1'b1;
          res_valid_next    = 1'b1;
          res_request_next  = req_ok;
          if (req_ok) begin
            ms_since_request_next = '0;
          end
        end
        CMD_UNIT_BYTE: begin
          if (!last_byte) begin
            zero_run_next          = scan_zero_run;
            header_next_next       = scan_header;
            hevc_irap_pending_next = scan_irap;
            key_seen_next          = scan_key;
          end else begin
            // Last byte: decide on the unit, then clear the scan
            zero_run_next          = 2'd0;
            header_next_next       = 1'b0;
            hevc_irap_pending_next = 1'b0;
            key_seen_next          = 1'b0;
            res_valid_next         = 1'b1;
            res_found_next         = unit_key;
            priority if (loss_suspected) begin
              res_verdict_next  = VERDICT_DROP_LOSS;
              awaiting_key_next = 1'b1;
              res_request_next  = req_ok;
              if (req_ok) begin
                ms_since_request_next = '0;
              end
            end else if (awaiting_key && !unit_key) begin
              res_verdict_next = VERDICT_DROP_WAIT;
              res_request_next = req_ok;
              if (req_ok) begin
                ms_since_request_next = '0;
              end
            end else begin
              res_verdict_next = VERDICT_PASS;
              if (unit_key) begin
                awaiting_key_next = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_waiting_next = awaiting_key_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode          <= CODEC_MODE_RESET;
      request_interval_ms <= REQ_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODEC_MODE:   codec_mode          <= cfg_data[1:0];
        CFG_REQ_INTERVAL: request_interval_ms <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Scan and gate state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run          <= 2'd0;
      header_next       <= 1'b0;
      hevc_irap_pending <= 1'b0;
      key_seen          <= 1'b0;
      awaiting_key      <= 1'b1;
      ms_since_request  <= MS_SATURATED;
    end else begin
      zero_run          <= zero_run_next;
      header_next       <= header_next_next;
      hevc_irap_pending <= hevc_irap_pending_next;
      key_seen          <= key_seen_next;
      awaiting_key      <= awaiting_key_next;
      ms_since_request  <= ms_since_request_next;
    end
  end

  // Output register: load a new result on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid_next;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid_next) begin
      res_verdict <= res_verdict_next;
      res_request <= res_request_next;
      res_found   <= res_found_next;
      res_waiting <= res_waiting_next;
    end
  end

  assign verdict          = res_verdict;
  assign keyframe_request = res_request;
  assign keyframe_found   = res_found;
  assign waiting_after    = res_waiting;

`ifndef NO_ASSERTIONS
  // A passing unit never leaves the gate waiting
  a_pass_clears_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_verdict == VERDICT_PASS) |-> (!res_waiting && !res_request))
    else $error("passing unit left wait set or issued a request");

  // Loss drops and events always leave the gate waiting
  a_drop_sets_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res_verdict == VERDICT_DROP_LOSS || res_verdict == VERDICT_EVENT))
      |-> res_waiting)
    else $error("loss drop or event did not set wait");

  // Events carry no keyframe judgement
  a_event_no_key: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_verdict == VERDICT_EVENT) |-> !res_found)
    else $error("event result reports a keyframe");

  // An issued request restarts the timer
  a_request_clears_timer: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid_next && res_request_next) |=> (ms_since_request == '0))
    else $error("request issued without clearing the timer");

  // A drop for waiting only happens on a non-key unit
  a_wait_drop_nonkey: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_verdict == VERDICT_DROP_WAIT) |-> (!res_found && res_waiting))
    else $error("key unit dropped while waiting");
`endif

endmodule
